// ===== rtl/core/rmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmfd_pkg
// Shared types and constants of the row mapped frame delay line.
// ----------------------------------------------------------------------------
package rmfd_pkg;

  localparam int COLUMNS     = 64;
  localparam int MAX_FRAMES  = 1024;

  localparam int COL_W       = $clog2(COLUMNS);
  localparam int SLOT_W      = $clog2(MAX_FRAMES);
  localparam int HELD_W      = SLOT_W + 1;
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int HIST_DEPTH  = MAX_FRAMES * COLUMNS;

  localparam int ROW_W       = 6;
  localparam int SAMPLE_W    = 8;
  localparam int AGE_W       = 10;

  localparam int BASE_W      = 6;
  localparam int EXTRA_W     = 8;
  localparam int SYM_W       = 4;
  localparam int VC_W        = 7;
  localparam int IH_W        = 7;
  localparam int TOTAL_W     = 9;
  localparam int MAPPED_W    = 9;
  localparam int PROD_W      = TOTAL_W + MAPPED_W;
  localparam int BOUND_W     = TOTAL_W + IH_W;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  // divider: 8 bit dividend, 4 quotient bits per cycle
  localparam int DIV_W       = 8;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_CYCLES  = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_DELAY   = 3'd0,
    REG_EXTRA_DELAY  = 3'd1,
    REG_KEEP_ORDER   = 3'd2,
    REG_SYMMETRY     = 3'd3,
    REG_COMB_ON      = 3'd4,
    REG_VOICE_COUNT  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel;
    logic [AGE_W-1:0]    frame_age;
  } rsp_t;

  typedef struct packed {
    logic [SYM_W-1:0] symmetry;
    logic             keep_order;
    logic             comb_on;
    logic [VC_W-1:0]  voice_count;
  } map_cfg_t;

endpackage

// ===== rtl/core/rmfd_ram.sv =====
// ----------------------------------------------------------------------------
// rmfd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rmfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rmfd_div.sv =====
// ----------------------------------------------------------------------------
// rmfd_div
// Iterative unsigned divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
module rmfd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rmfd_pkg::VC_W-1:0]     dividend,
  input  logic [rmfd_pkg::VC_W-1:0]     divisor,
  output logic                          done,
  output logic [rmfd_pkg::VC_W-1:0]     quotient,
  output logic [rmfd_pkg::VC_W-1:0]     remainder
);
  import rmfd_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VC_W-1:0]      rem;
  logic [DIV_W-1:0]     quo;
  logic [VC_W-1:0]      dvs;
  logic [VC_W-1:0]      rem_next;
  logic [DIV_W-1:0]     quo_next;

  always_comb begin
    logic [VC_W:0] r8;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_STEPS; i++) begin
      r8       = {rem_next, quo_next[DIV_W-1]};
      quo_next = {quo_next[DIV_W-2:0], 1'b0};
      if (r8 >= {1'b0, dvs}) begin
        rem_next    = VC_W'(r8 - {1'b0, dvs});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = r8[VC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= DIV_W'(dividend);
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient  = quo[VC_W-1:0];
  assign remainder = rem;

endmodule

// ===== rtl/core/rmfd_map.sv =====
// ----------------------------------------------------------------------------
// rmfd_map
// Row mapping: symmetry fold, optional inversion, comb alternation.
// ----------------------------------------------------------------------------
module rmfd_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rmfd_pkg::ROW_W-1:0]    row,
  input  rmfd_pkg::map_cfg_t            cfg,
  output logic                          done,
  output logic [rmfd_pkg::MAPPED_W-1:0] mapped
);
  import rmfd_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_FOLD  = 4'b0010,
    M_IDX   = 4'b0100,
    M_FINAL = 4'b1000
  } map_state_t;

  map_state_t       state;
  logic [ROW_W-1:0] row_q;
  logic [VC_W-1:0]  fold_q;
  logic [7:0]       idx2_q;

  logic            div_start;
  logic [VC_W-1:0] div_dividend;
  logic [VC_W-1:0] div_divisor;
  logic            div_done;
  logic [VC_W-1:0] div_quo;
  logic [VC_W-1:0] div_rem;
  logic [VC_W-1:0] fold_c;

  logic signed [8:0] t;
  logic [8:0]        t_abs;
  logic [7:0]        idx1;
  logic [7:0]        idx2;
  logic signed [9:0] idx3;
  logic signed [9:0] vc_s;
  logic signed [9:0] term;
  logic signed [9:0] diff;
  logic [MAPPED_W-1:0] mapped_c;

  assign fold_c = (div_quo == '0) ? VC_W'(1) : div_quo;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = cfg.voice_count;
    div_divisor  = VC_W'(cfg.symmetry) + VC_W'(1);
    if (state == M_IDLE && start) begin
      div_start = 1'b1;
    end else if (state == M_FOLD && div_done) begin
      div_start    = 1'b1;
      div_dividend = VC_W'(row_q);
      div_divisor  = fold_c;
    end
  end

  rmfd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // fold - |(q odd ? fold : 0) - r| + symmetry
  always_comb begin
    t     = $signed({2'b00, (div_quo[0] ? fold_q : VC_W'(0))}) - $signed({2'b00, div_rem});
    t_abs = t[8] ? 9'(-t) : 9'(t);
    idx1  = {1'b0, fold_q} - t_abs[7:0];
    idx2  = idx1 + 8'(cfg.symmetry);
  end

  // inversion and comb reflection
  always_comb begin
    vc_s = $signed({3'b000, cfg.voice_count});
    if (cfg.keep_order) begin
      idx3 = $signed({2'b00, idx2_q});
    end else begin
      idx3 = vc_s - $signed({2'b00, idx2_q}) + 10'sd1;
    end
    if (cfg.comb_on && idx3[0]) begin
      term = idx3[9] ? -vc_s : vc_s;
    end else begin
      term = '0;
    end
    diff     = term - idx3;
    mapped_c = diff[9] ? MAPPED_W'(-diff) : diff[MAPPED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE:  if (start) state <= M_FOLD;
        M_FOLD:  if (div_done) state <= M_IDX;
        M_IDX:   if (div_done) state <= M_FINAL;
        M_FINAL: begin
          state <= M_IDLE;
          done  <= 1'b1;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == M_IDLE && start) begin
      row_q <= row;
    end
    if (state == M_FOLD && div_done) begin
      fold_q <= fold_c;
    end
    if (state == M_IDX && div_done) begin
      idx2_q <= idx2;
    end
    if (state == M_FINAL) begin
      mapped <= mapped_c;
    end
  end

endmodule

// ===== rtl/core/row_mapped_frame_delay_line.sv =====
// ----------------------------------------------------------------------------
// row_mapped_frame_delay_line
// History of one-line frames read back through a row to frame-age mapping.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall/req) carries write and read items.
// A write item stores one column of the frame under construction in the
// history RAM in its accept cycle; with frame_end set it also commits the
// frame, and the block stalls requests in its commit state while the frame
// count is trimmed. A read item runs the row through the mapping unit, whose
// shared divider (four quotient bits per cycle) is used twice, then scales
// by the total delay, selects a past frame and reads the RAM.
// A read holds off further requests from accept until its result is loaded;
// the next request is taken in the cycle after the result is loaded. A plain
// write does not hold off the next request.
// The result sits in an output register: a stall on the response side holds
// rsp stable and only blocks the following read at its final load step.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
// Reset clears the frame count and newest slot and loads register defaults;
// history contents stay undefined until written, no clearing pass is done.
// ----------------------------------------------------------------------------
module row_mapped_frame_delay_line (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rmfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  rmfd_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output rmfd_pkg::rsp_t                  rsp
);
  import rmfd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MAP    = 5'b00010,
    S_READ   = 5'b00100,
    S_OUT    = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state;

  logic [BASE_W-1:0]  base_delay;
  logic [EXTRA_W-1:0] extra_delay;
  logic               keep_order;
  logic [SYM_W-1:0]   symmetry;
  logic               comb_on;
  logic [VC_W-1:0]    voice_count;
  logic [IH_W-1:0]    image_height;

  logic [SLOT_W-1:0]  newest_slot;
  logic [HELD_W-1:0]  frames_held;
  logic [HELD_W-1:0]  frames_held_next;

  logic [COL_W-1:0]   col_q;
  logic [PROD_W-1:0]  age_q;
  logic [AGE_W-1:0]   age_sel_q;

  logic               accept;
  logic               wr_item;
  logic               rd_item;
  logic [SLOT_W-1:0]  pending_slot;
  logic [TOTAL_W-1:0] total;
  logic [BOUND_W-1:0] bound;
  logic [HELD_W-1:0]  trimmed;
  logic [AGE_W-1:0]   age_sel;
  logic [SLOT_W-1:0]  rd_slot;
  logic               out_load;

  map_cfg_t              map_cfg;
  logic                  map_done;
  logic [MAPPED_W-1:0]   mapped;
  logic [SAMPLE_W-1:0]   rd_data;

  assign req_stall    = (state != S_IDLE);
  assign accept       = req_valid && !req_stall;
  assign wr_item      = accept && (req.kind == KIND_WRITE);
  assign rd_item      = accept && (req.kind == KIND_READ);
  assign pending_slot = newest_slot + SLOT_W'(1);
  assign total        = TOTAL_W'(base_delay) + TOTAL_W'(extra_delay);

  assign map_cfg.symmetry    = symmetry;
  assign map_cfg.keep_order  = keep_order;
  assign map_cfg.comb_on     = comb_on;
  assign map_cfg.voice_count = voice_count;

  rmfd_map u_map (
    .clk    (clk),
    .rst    (rst),
    .start  (rd_item),
    .row    (req.row),
    .cfg    (map_cfg),
    .done   (map_done),
    .mapped (mapped)
  );

  // age outside the held history falls back to the newest frame
  assign age_sel = (age_q < PROD_W'(frames_held)) ? age_q[AGE_W-1:0] : '0;
  assign rd_slot = newest_slot - SLOT_W'(age_sel);

  rmfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HIST_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (wr_item),
    .waddr ({pending_slot, req.column}),
    .wdata (req.sample),
    .re    (state == S_READ),
    .raddr ({rd_slot, col_q}),
    .rdata (rd_data)
  );

  // commit: trim to total * image_height, then count the new frame, saturating at MAX_FRAMES - 1
  always_comb begin
    bound   = BOUND_W'(total) * BOUND_W'(image_height);
    trimmed = (BOUND_W'(frames_held) > bound) ? HELD_W'(bound) : frames_held;
    if (trimmed < HELD_W'(MAX_FRAMES - 1)) begin
      frames_held_next = trimmed + HELD_W'(1);
    end else begin
      frames_held_next = trimmed;
    end
  end

  assign out_load = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      newest_slot  <= '0;
      frames_held  <= '0;
      base_delay   <= BASE_W'(1);
      extra_delay  <= '0;
      keep_order   <= 1'b0;
      symmetry     <= '0;
      comb_on      <= 1'b0;
      voice_count  <= VC_W'(64);
      image_height <= IH_W'(64);
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BASE_DELAY:   base_delay   <= cfg_data[BASE_W-1:0];
          REG_EXTRA_DELAY:  extra_delay  <= cfg_data[EXTRA_W-1:0];
          REG_KEEP_ORDER:   keep_order   <= cfg_data[0];
          REG_SYMMETRY:     symmetry     <= cfg_data[SYM_W-1:0];
          REG_COMB_ON:      comb_on      <= cfg_data[0];
          REG_VOICE_COUNT:  voice_count  <= cfg_data[VC_W-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[IH_W-1:0];
          default: ;
        endcase
      end

      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (rd_item) begin
            state <= S_MAP;
          end else if (wr_item && req.frame_end) begin
            state <= S_COMMIT;
          end
        end
        S_MAP:  if (map_done) state <= S_READ;
        S_READ: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_COMMIT: begin
          frames_held <= frames_held_next;
          newest_slot <= pending_slot;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_item) begin
      col_q <= req.column;
    end
    if (state == S_MAP && map_done) begin
      age_q <= PROD_W'(total) * PROD_W'(mapped);
    end
    if (state == S_READ) begin
      age_sel_q <= age_sel;
    end
    if (out_load) begin
      rsp.pixel     <= rd_data;
      rsp.frame_age <= age_sel_q;
    end
  end

endmodule

// ===== rtl/core/rmfd_checker.sv =====
// ----------------------------------------------------------------------------
// rmfd_checker
// Port-level checks of the row mapped frame delay line, bound to the top.
// ----------------------------------------------------------------------------
module rmfd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input rmfd_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input rmfd_pkg::rsp_t rsp
);
  import rmfd_pkg::*;

  logic rd_acc;
  logic wr_plain_acc;
  logic wr_commit_acc;

  assign rd_acc        = req_valid && !req_stall && (req.kind == KIND_READ);
  assign wr_plain_acc  = req_valid && !req_stall && (req.kind == KIND_WRITE) && !req.frame_end;
  assign wr_commit_acc = req_valid && !req_stall && (req.kind == KIND_WRITE) && req.frame_end;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    rd_acc |=> req_stall)
    else $error("request taken while a read is in flight");

  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    wr_plain_acc |=> !req_stall)
    else $error("plain write item held off the next request");

  a_commit_one: assert property (@(posedge clk) disable iff (rst)
    wr_commit_acc |=> req_stall ##1 !req_stall)
    else $error("frame commit did not take exactly one extra cycle");

endmodule

bind row_mapped_frame_delay_line rmfd_checker u_rmfd_checker (.*);
